// File: rtl/ftk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ftk_pkg;

	// Field widths of the command and result transactions
	localparam int CMD_W     = 2;
	localparam int IDX_W     = 7;
	localparam int VAL_W     = 16;
	localparam int ID_W      = 31;
	localparam int RID_W     = 32;
	localparam int DIST_W    = 48;
	localparam int SQ_W      = 32;
	localparam int KEEP_W    = 5;
	localparam int DIM_W     = 8;
	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 1;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CAND = 2'd1;
	localparam logic [CMD_W-1:0] CMD_EMIT = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DIMENSION  = 1'b1;

	// Register reset values
	localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd10;
	localparam logic [DIM_W-1:0]  DIM_RESET  = 8'd128;

	// Padding for empty result slots
	localparam logic [RID_W-1:0]  EMPTY_ID = '1;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	// Operation handed from the front end to the back end
	typedef enum logic [1:0] {
		OP_LOAD,
		OP_CAND,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t                     op;
		logic [IDX_W-1:0]        index;
		logic signed [VAL_W-1:0] value;
		logic [ID_W-1:0]         id;
		logic                    eligible;
		logic                    is_first;
		logic                    is_last;
	} item_t;

endpackage

`default_nettype wire

// File: rtl/ftk_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ftk_front import ftk_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [CMD_W-1:0]        command,
	input  logic [IDX_W-1:0]        component_index,
	input  logic signed [VAL_W-1:0] component_value,
	input  logic [ID_W-1:0]         candidate_id,
	input  logic                    eligible,
	input  logic [DIM_W-1:0]        dim_eff,
	output item_t                   head,
	output logic                    head_valid,
	input  logic                    pop
);

	localparam int QD = 2;

	item_t      item_d;
	logic       keep_item;
	logic       push;
	item_t      q_mem [QD];
	logic       q_wr_q;
	logic       q_rd_q;
	logic [1:0] q_cnt_q;

	// Classify the incoming transaction; out-of-range candidate components drop here
	always_comb begin
		item_d.op       = OP_LOAD;
		item_d.index    = component_index;
		item_d.value    = component_value;
		item_d.id       = candidate_id;
		item_d.eligible = eligible;
		item_d.is_first = (component_index == '0);
		item_d.is_last  = ({1'b0, component_index} == (dim_eff - DIM_W'(1)));
		keep_item       = 1'b0;
		case (command)
			CMD_LOAD: begin
				item_d.op = OP_LOAD;
				keep_item = 1'b1;
			end
			CMD_CAND: begin
				item_d.op = OP_CAND;
				keep_item = ({1'b0, component_index} < dim_eff);
			end
			CMD_EMIT: begin
				item_d.op = OP_EMIT;
				keep_item = 1'b1;
			end
			default: keep_item = 1'b0;
		endcase
	end

	assign busy       = (q_cnt_q == 2'd2);
	assign push       = start && !busy && keep_item;
	assign head_valid = (q_cnt_q != 2'd0);
	assign head       = q_mem[q_rd_q];

	// Two-entry queue toward the back end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_wr_q  <= 1'b0;
			q_rd_q  <= 1'b0;
			q_cnt_q <= 2'd0;
		end else begin
			if (push) q_wr_q <= ~q_wr_q;
			if (pop) q_rd_q <= ~q_rd_q;
			case ({push, pop})
				2'b10:   q_cnt_q <= q_cnt_q + 2'd1;
				2'b01:   q_cnt_q <= q_cnt_q - 2'd1;
				default: q_cnt_q <= q_cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_mem[q_wr_q] <= item_d;
	end

endmodule

`default_nettype wire

// File: rtl/ftk_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ftk_back import ftk_pkg::*; #(
	parameter int MAX_KEEP      = 16,
	parameter int MAX_DIMENSION = 128,
	parameter int KW            = $clog2(MAX_KEEP + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  item_t                   head,
	input  logic                    head_valid,
	output logic                    pop,
	input  logic [KW-1:0]           keep_eff,
	output logic                    result_valid,
	output logic signed [RID_W-1:0] result_id,
	output logic [DIST_W-1:0]       result_distance,
	output logic                    last
);

	localparam int LW     = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
	localparam int QDEPTH = (MAX_DIMENSION < (1 << IDX_W)) ? MAX_DIMENSION : (1 << IDX_W);
	localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ACCUM,
		ST_INSERT,
		ST_EMIT
	} state_t;

	state_t                  state_q;
	item_t                   cur_q;
	logic signed [VAL_W-1:0] qmem [QDEPTH];
	logic signed [VAL_W-1:0] qdata_q;
	logic [QAW-1:0]          qaddr;
	logic                    mem_we;
	logic                    mem_re;
	logic [SQ_W-1:0]         sq_q;
	logic [DIST_W-1:0]       acc_q;
	logic [DIST_W-1:0]       dist_q;
	logic [KW-1:0]           count_q;
	logic [KW-1:0]           emit_cnt_q;

	logic [DIST_W-1:0]       rd_q  [MAX_KEEP];
	logic [RID_W-1:0]        rid_q [MAX_KEEP];
	logic [DIST_W-1:0]       ins_d [MAX_KEEP];
	logic [RID_W-1:0]        ins_i [MAX_KEEP];
	logic [DIST_W-1:0]       sh_d  [MAX_KEEP];
	logic [RID_W-1:0]        sh_i  [MAX_KEEP];
	logic [MAX_KEEP-1:0]     lt;
	logic [MAX_KEEP-1:0]     dlt;

	logic signed [VAL_W:0]   diff;
	logic [VAL_W:0]          mag;
	logic [VAL_W-1:0]        mag_u;
	logic [SQ_W-1:0]         sq_d;
	logic [DIST_W-1:0]       base;
	logic [DIST_W:0]         sum;
	logic [DIST_W-1:0]       sat;
	logic [RID_W-1:0]        new_id;
	logic [KW-1:0]           keep_m1;
	logic                    full;
	logic [KW-1:0]           n_use;
	logic                    accept;
	logic                    do_ins;
	logic                    do_shift;

	assign pop    = (state_q == ST_IDLE) && head_valid;
	assign qaddr  = head.index[QAW-1:0];
	assign mem_we = pop && (head.op == OP_LOAD) && (32'(head.index) < QDEPTH);
	assign mem_re = pop && (head.op == OP_CAND);

	// Query store: one write or one read per cycle, registered read
	always_ff @(posedge clk) begin
		if (mem_we) qmem[qaddr] <= head.value;
		if (mem_re) qdata_q <= qmem[qaddr];
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= head;
	end

	// Squared difference and saturating accumulate
	always_comb begin
		diff  = {cur_q.value[VAL_W-1], cur_q.value} - {qdata_q[VAL_W-1], qdata_q};
		mag   = diff[VAL_W] ? (-diff) : diff;
		mag_u = mag[VAL_W-1:0];
		sq_d  = mag_u * mag_u;
		base  = cur_q.is_first ? '0 : acc_q;
		sum   = {1'b0, base} + {{(DIST_W + 1 - SQ_W){1'b0}}, sq_q};
		sat   = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
	end

	// Insertion control: list full means only a strictly smaller distance enters
	assign new_id   = {1'b0, cur_q.id};
	assign keep_m1  = keep_eff - KW'(1);
	assign full     = (count_q >= keep_eff);
	assign n_use    = full ? keep_m1 : count_q;
	assign accept   = !full || dlt[keep_m1[LW-1:0]];
	assign do_ins   = (state_q == ST_INSERT) && accept;
	assign do_shift = (state_q == ST_EMIT);

	// Per-slot compare, insert and emit shift
	for (genvar g = 0; g < MAX_KEEP; g++) begin : g_slot
		assign dlt[g] = (dist_q < rd_q[g]);
		assign lt[g]  = (KW'(g) < n_use) &&
			((rd_q[g] < dist_q) || ((rd_q[g] == dist_q) && (rid_q[g] < new_id)));
		if (g == 0) begin : g_head
			assign ins_d[g] = lt[g] ? rd_q[g] : dist_q;
			assign ins_i[g] = lt[g] ? rid_q[g] : new_id;
		end else begin : g_body
			assign ins_d[g] = lt[g] ? rd_q[g] : (lt[g-1] ? dist_q : rd_q[g-1]);
			assign ins_i[g] = lt[g] ? rid_q[g] : (lt[g-1] ? new_id : rid_q[g-1]);
		end
		if (g == MAX_KEEP - 1) begin : g_tail
			assign sh_d[g] = rd_q[g];
			assign sh_i[g] = rid_q[g];
		end else begin : g_mid
			assign sh_d[g] = rd_q[g+1];
			assign sh_i[g] = rid_q[g+1];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_KEEP; i++) begin
			if (do_ins) begin
				rd_q[i]  <= ins_d[i];
				rid_q[i] <= ins_i[i];
			end else if (do_shift) begin
				rd_q[i]  <= sh_d[i];
				rid_q[i] <= sh_i[i];
			end
		end
	end

	// Sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			sq_q            <= '0;
			acc_q           <= '0;
			dist_q          <= '0;
			count_q         <= '0;
			emit_cnt_q      <= '0;
			result_valid    <= 1'b0;
			result_id       <= '0;
			result_distance <= '0;
			last            <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			last         <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					// a smaller keep_count cuts the list
					if (count_q > keep_eff) count_q <= keep_eff;
					if (pop) begin
						case (head.op)
							OP_CAND: state_q <= ST_SQUARE;
							OP_EMIT: begin
								emit_cnt_q <= '0;
								state_q    <= ST_EMIT;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_SQUARE: begin
					sq_q    <= sq_d;
					state_q <= ST_ACCUM;
				end
				ST_ACCUM: begin
					if (cur_q.is_last) begin
						acc_q <= '0;
						if (cur_q.eligible) begin
							dist_q  <= sat;
							state_q <= ST_INSERT;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						acc_q   <= sat;
						state_q <= ST_IDLE;
					end
				end
				ST_INSERT: begin
					if (accept) count_q <= n_use + KW'(1);
					state_q <= ST_IDLE;
				end
				ST_EMIT: begin
					result_valid <= 1'b1;
					if (emit_cnt_q < count_q) begin
						result_id       <= rid_q[0];
						result_distance <= rd_q[0];
					end else begin
						result_id       <= EMPTY_ID;
						result_distance <= DIST_MAX;
					end
					emit_cnt_q <= emit_cnt_q + KW'(1);
					if (emit_cnt_q == keep_m1) begin
						last    <= 1'b1;
						count_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/filtered_top_k_l2_search.sv
`timescale 1ns / 1ps
`default_nettype none

// Query load: one transaction per cycle through the queue while busy is low; store written on pop.
// Candidate component: the back-end sequencer steps through pop/read, square and accumulate,
// plus a sorted insert on an eligible last component; the 2-entry queue sets when busy rises.
// Emit: after queue, pop and emit state, the clamped keep_count results come on consecutive cycles.
// Results are strobed for one cycle; the receiver cannot stall.
// Reset (async, active low): keep_count 10, dimension 128, list empty, no clearing pass.

module filtered_top_k_l2_search import ftk_pkg::*; #(
	parameter int MAX_KEEP      = 16,
	parameter int MAX_DIMENSION = 128
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [CMD_W-1:0]        command,
	input  logic [IDX_W-1:0]        component_index,
	input  logic signed [VAL_W-1:0] component_value,
	input  logic [ID_W-1:0]         candidate_id,
	input  logic                    eligible,
	input  logic                    cfg_write,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	output logic                    result_valid,
	output logic signed [RID_W-1:0] result_id,
	output logic [DIST_W-1:0]       result_distance,
	output logic                    last
);

	localparam int KW = $clog2(MAX_KEEP + 1);

	logic [KEEP_W-1:0] keep_count_q;
	logic [DIM_W-1:0]  dimension_q;
	logic [KW-1:0]     keep_eff;
	logic [DIM_W-1:0]  dim_eff;
	item_t             head;
	logic              head_valid;
	logic              pop;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_count_q <= KEEP_RESET;
			dimension_q  <= DIM_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_KEEP_COUNT: keep_count_q <= cfg_data[KEEP_W-1:0];
				REG_DIMENSION:  dimension_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp register values into their working ranges
	always_comb begin
		if (keep_count_q == '0) keep_eff = KW'(1);
		else if (32'(keep_count_q) > MAX_KEEP) keep_eff = KW'(MAX_KEEP);
		else keep_eff = KW'(keep_count_q);

		if (dimension_q == '0) dim_eff = DIM_W'(1);
		else if (32'(dimension_q) > MAX_DIMENSION) dim_eff = DIM_W'(MAX_DIMENSION);
		else dim_eff = dimension_q;
	end

	ftk_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.command         (command),
		.component_index (component_index),
		.component_value (component_value),
		.candidate_id    (candidate_id),
		.eligible        (eligible),
		.dim_eff         (dim_eff),
		.head            (head),
		.head_valid      (head_valid),
		.pop             (pop)
	);

	ftk_back #(
		.MAX_KEEP      (MAX_KEEP),
		.MAX_DIMENSION (MAX_DIMENSION),
		.KW            (KW)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (head),
		.head_valid      (head_valid),
		.pop             (pop),
		.keep_eff        (keep_eff),
		.result_valid    (result_valid),
		.result_id       (result_id),
		.result_distance (result_distance),
		.last            (last)
	);

endmodule

`default_nettype wire

// File: rtl/ftk_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ftk_checker import ftk_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    result_valid,
	input logic signed [RID_W-1:0] result_id,
	input logic [DIST_W-1:0]       result_distance,
	input logic                    last
);

	// An emit run ends with a gap before the next one can start
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last) |=> !result_valid)
		else $error("result strobe right after the last result of a run");

	// Empty slots carry the maximum distance
	a_pad_distance: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result_id == EMPTY_ID)) |-> (result_distance == DIST_MAX))
		else $error("empty slot without maximum distance");

	// Once padding starts, the rest of the run is padding
	a_pad_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !last && (result_id == EMPTY_ID)) |=>
		(result_valid && (result_id == EMPTY_ID)))
		else $error("ranked result after an empty slot");

	// Results of one run come out contiguous and in ascending distance
	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !last) |=>
		(result_valid && (result_distance >= $past(result_distance))))
		else $error("emit run broken or out of order");

endmodule

bind filtered_top_k_l2_search ftk_checker u_ftk_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.result_valid    (result_valid),
	.result_id       (result_id),
	.result_distance (result_distance),
	.last            (last)
);

`default_nettype wire
